FILE: rtl/dxt_pkg.sv
// ----------------------------------------------------------------------------
// DXT block decoder package
// Word types, format codes and the constant dividers shared by the decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } format_e;

  localparam int unsigned NumLanes = 4;

  localparam logic [31:0] TransparentPx = 32'h00FF_FF00;
  localparam logic [7:0]  AlphaOpaque   = 8'hFF;
  localparam logic [7:0]  AlphaClear    = 8'h00;

  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] pixel_0;
    logic [31:0] pixel_1;
    logic [31:0] pixel_2;
    logic [31:0] pixel_3;
    logic        last_row;
  } out_word_t;

  typedef logic [3:0][31:0] pal_t;
  typedef logic [7:0][7:0]  atab_t;

  // x / 3 for x below 768, by reciprocal multiplication.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  // x / 5 for x below 1280.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

  // x / 7 for x below 1792.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

endpackage

FILE: rtl/dxt_block_decoder.sv
// ----------------------------------------------------------------------------
// DXT block decoder
// Decodes DXT1/DXT3/DXT5 4x4 blocks into four rows of 32-bit pixels.
// ----------------------------------------------------------------------------
// When a block word is accepted, its colour palette and alpha table are
// built and registered; four pixel lanes then decode one texel row per
// cycle while the output side does not stall, and the rows leave through
// an output register, top row first. The next block is accepted in the
// cycle in which the last row of the previous block moves on. The format
// register must only be written while no block is in flight.
module dxt_block_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dxt_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dxt_pkg::out_word_t out_data_o
);
  import dxt_pkg::*;

  logic [1:0]  format_q;
  logic        blk_valid_q;
  logic [1:0]  row_q;
  pal_t        pal_d, pal_q;
  atab_t       atab_d, atab_q;
  logic [31:0] codes_q;
  logic [63:0] nibbles_q;
  logic [47:0] acodes_q;
  logic        out_valid_q;
  out_word_t   out_q;

  logic        out_adv;
  logic        emit;
  logic        blk_done;
  logic        accept;
  logic [31:0] lane_px [NumLanes];

  assign cfg_ready_o = 1'b1;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign emit       = blk_valid_q && out_adv;
  assign blk_done   = emit && (row_q == 2'd3);
  assign in_stall_o = blk_valid_q && !blk_done;
  assign accept     = in_valid_i && !in_stall_o;

  dxt_palette u_palette (
    .endpoint0_i (in_data_i.color_block[15:0]),
    .endpoint1_i (in_data_i.color_block[31:16]),
    .pal_o       (pal_d)
  );

  dxt_alpha_table u_alpha_table (
    .alpha0_i (in_data_i.alpha_block[7:0]),
    .alpha1_i (in_data_i.alpha_block[15:8]),
    .atab_o   (atab_d)
  );

  for (genvar n = 0; n < NumLanes; n++) begin : g_lane
    dxt_lane u_lane (
      .format_i       (format_q),
      .pal_i          (pal_q),
      .atab_i         (atab_q),
      .color_code_i   (codes_q[2*n +: 2]),
      .alpha_nibble_i (nibbles_q[4*n +: 4]),
      .alpha_code_i   (acodes_q[3*n +: 3]),
      .pixel_o        (lane_px[n])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q    <= FMT_DXT1;
      blk_valid_q <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        format_q <= cfg_data_i;
      end
      if (accept) begin
        blk_valid_q <= 1'b1;
        row_q       <= '0;
      end else if (emit) begin
        row_q <= row_q + 2'd1;
        if (blk_done) begin
          blk_valid_q <= 1'b0;
        end
      end
      if (out_adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pal_q     <= pal_d;
      atab_q    <= atab_d;
      codes_q   <= in_data_i.color_block[63:32];
      nibbles_q <= in_data_i.alpha_block;
      acodes_q  <= in_data_i.alpha_block[63:16];
    end else if (emit) begin
      codes_q   <= {8'd0, codes_q[31:8]};
      nibbles_q <= {16'd0, nibbles_q[63:16]};
      acodes_q  <= {12'd0, acodes_q[47:12]};
    end
    if (emit) begin
      out_q.row_index <= row_q;
      out_q.pixel_0   <= lane_px[0];
      out_q.pixel_1   <= lane_px[1];
      out_q.pixel_2   <= lane_px[2];
      out_q.pixel_3   <= lane_px[3];
      out_q.last_row  <= (row_q == 2'd3);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/dxt_palette.sv
// ----------------------------------------------------------------------------
// DXT colour palette
// Widens the two 565 endpoints and builds the four-entry colour palette.
// ----------------------------------------------------------------------------
module dxt_palette (
  input  logic [15:0]   endpoint0_i,
  input  logic [15:0]   endpoint1_i,
  output dxt_pkg::pal_t pal_o
);
  import dxt_pkg::*;

  logic [7:0] c0 [3];
  logic [7:0] c1 [3];
  logic [7:0] third0 [3];
  logic [7:0] third1 [3];
  logic [7:0] half [3];
  logic [8:0] sum2 [3];

  assign c0[0] = {endpoint0_i[15:11], 3'b000};
  assign c0[1] = {endpoint0_i[10:5], 2'b00};
  assign c0[2] = {endpoint0_i[4:0], 3'b000};
  assign c1[0] = {endpoint1_i[15:11], 3'b000};
  assign c1[1] = {endpoint1_i[10:5], 2'b00};
  assign c1[2] = {endpoint1_i[4:0], 3'b000};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      third0[c] = div3({1'b0, c0[c], 1'b0} + {2'b00, c1[c]});
      third1[c] = div3({2'b00, c0[c]} + {1'b0, c1[c], 1'b0});
      sum2[c]   = {1'b0, c0[c]} + {1'b0, c1[c]};
      half[c]   = sum2[c][8:1];
    end
  end

  always_comb begin
    pal_o[0] = {AlphaOpaque, c0[2], c0[1], c0[0]};
    pal_o[1] = {AlphaOpaque, c1[2], c1[1], c1[0]};
    if (endpoint0_i > endpoint1_i) begin
      pal_o[2] = {AlphaOpaque, third0[2], third0[1], third0[0]};
      pal_o[3] = {AlphaOpaque, third1[2], third1[1], third1[0]};
    end else begin
      pal_o[2] = {AlphaOpaque, half[2], half[1], half[0]};
      pal_o[3] = TransparentPx;
    end
  end

endmodule

FILE: rtl/dxt_alpha_table.sv
// ----------------------------------------------------------------------------
// DXT interpolated alpha table
// Builds the eight-entry alpha table from the two alpha endpoints.
// ----------------------------------------------------------------------------
module dxt_alpha_table (
  input  logic [7:0]     alpha0_i,
  input  logic [7:0]     alpha1_i,
  output dxt_pkg::atab_t atab_o
);
  import dxt_pkg::*;

  logic [10:0] s7;
  logic [10:0] s5;

  always_comb begin
    s7 = '0;
    s5 = '0;
    atab_o[0] = alpha0_i;
    atab_o[1] = alpha1_i;
    if (alpha0_i > alpha1_i) begin
      for (int k = 1; k <= 6; k++) begin
        s7 = {3'd0, alpha0_i} * 11'(7 - k) + {3'd0, alpha1_i} * 11'(k);
        atab_o[k + 1] = div7(s7);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        s5 = {3'd0, alpha0_i} * 11'(5 - k) + {3'd0, alpha1_i} * 11'(k);
        atab_o[k + 1] = div5(s5);
      end
      atab_o[6] = AlphaClear;
      atab_o[7] = AlphaOpaque;
    end
  end

endmodule

FILE: rtl/dxt_lane.sv
// ----------------------------------------------------------------------------
// DXT pixel lane
// Decodes one texel of a row: palette colour plus alpha for the format.
// ----------------------------------------------------------------------------
module dxt_lane (
  input  logic [1:0]     format_i,
  input  dxt_pkg::pal_t  pal_i,
  input  dxt_pkg::atab_t atab_i,
  input  logic [1:0]     color_code_i,
  input  logic [3:0]     alpha_nibble_i,
  input  logic [2:0]     alpha_code_i,
  output logic [31:0]    pixel_o
);
  import dxt_pkg::*;

  logic [31:0] px;

  assign px = pal_i[color_code_i];

  always_comb begin
    case (format_i)
      FMT_DXT3: pixel_o = {alpha_nibble_i, alpha_nibble_i, px[23:0]};
      FMT_DXT5: pixel_o = {atab_i[alpha_code_i], px[23:0]};
      default:  pixel_o = px;
    endcase
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DXT block decoder testbench
// Sends 4x4 texel blocks to the decoder under each format setting, including
// the unused format code, and checks every row word against a behavioural
// decode of the block. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import dxt_pkg::*;

  localparam logic [1:0]  FmtUnused    = 2'd3;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned NumDirected  = 6;
  localparam int unsigned RandPerPhase = 55;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 2000;

  localparam logic [1:0] PhaseFormat [NumPhases] = '{
    FMT_DXT1, FMT_DXT3, FMT_DXT5, FmtUnused, FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_DXT5
  };

  // The blocks cover both colour modes, equal endpoints, all-zero and all-one
  // words, every texel code and both alpha interpolation modes.
  localparam in_word_t DirectedBlocks [NumDirected] = '{
    {64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
    {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    {64'hE4E4_E4E4_0000_FFFF, 64'hFAC6_88FA_C688_00FF},
    {64'h1B1B_1B1B_FFFF_0000, 64'h0539_7705_3977_FF00},
    {64'h9C63_D2B1_07E0_F800, 64'h0123_4567_89AB_F010},
    {64'hE4E4_E4E4_1234_1234, 64'hFEDC_BA98_7654_8080}
  };

  class dxt_row_scoreboard;
    logic [1:0]  format_code;
    out_word_t   rows_due [$];
    int unsigned mismatches;
    int unsigned rows_checked;

    function new();
      format_code  = FMT_DXT1;
      mismatches   = 0;
      rows_checked = 0;
    endfunction

    function void note_block(in_word_t blk);
      logic [15:0] ep [2];
      logic [7:0]  r [2];
      logic [7:0]  g [2];
      logic [7:0]  b [2];
      logic [31:0] pal [4];
      int unsigned a0, a1;
      int unsigned atab [8];
      logic [31:0] px [4];
      logic [3:0]  nib;
      logic [2:0]  acode;
      out_word_t   row;
      ep[0] = blk.color_block[15:0];
      ep[1] = blk.color_block[31:16];
      for (int i = 0; i < 2; i++) begin
        r[i] = {ep[i][15:11], 3'b000};
        g[i] = {ep[i][10:5], 2'b00};
        b[i] = {ep[i][4:0], 3'b000};
      end
      pal[0] = {AlphaOpaque, b[0], g[0], r[0]};
      pal[1] = {AlphaOpaque, b[1], g[1], r[1]};
      if (ep[0] > ep[1]) begin
        pal[2] = {AlphaOpaque, 8'((2 * b[0] + b[1]) / 3), 8'((2 * g[0] + g[1]) / 3),
                  8'((2 * r[0] + r[1]) / 3)};
        pal[3] = {AlphaOpaque, 8'((b[0] + 2 * b[1]) / 3), 8'((g[0] + 2 * g[1]) / 3),
                  8'((r[0] + 2 * r[1]) / 3)};
      end else begin
        pal[2] = {AlphaOpaque, 8'((b[0] + b[1]) / 2), 8'((g[0] + g[1]) / 2),
                  8'((r[0] + r[1]) / 2)};
        pal[3] = TransparentPx;
      end
      a0 = 32'(blk.alpha_block[7:0]);
      a1 = 32'(blk.alpha_block[15:8]);
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k <= 6; k++) atab[k + 1] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
        for (int k = 1; k <= 4; k++) atab[k + 1] = ((5 - k) * a0 + k * a1) / 5;
        atab[6] = 32'(AlphaClear);
        atab[7] = 32'(AlphaOpaque);
      end
      for (int ri = 0; ri < 4; ri++) begin
        for (int ci = 0; ci < 4; ci++) begin
          px[ci] = pal[blk.color_block[32 + 8 * ri + 2 * ci +: 2]];
          case (format_code)
            FMT_DXT3: begin
              nib = blk.alpha_block[16 * ri + 4 * ci +: 4];
              px[ci][31:24] = {nib, nib};
            end
            FMT_DXT5: begin
              acode = blk.alpha_block[16 + 3 * (4 * ri + ci) +: 3];
              px[ci][31:24] = 8'(atab[acode]);
            end
            default: begin
            end
          endcase
        end
        row.row_index = 2'(ri);
        row.pixel_0   = px[0];
        row.pixel_1   = px[1];
        row.pixel_2   = px[2];
        row.pixel_3   = px[3];
        row.last_row  = (ri == 3);
        rows_due.push_back(row);
      end
    endfunction

    function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_row(out_word_t got);
      out_word_t want;
      if (rows_due.size() == 0) begin
        $display("%0t ns: row word %0d arrived with no block outstanding, expected none, actual %h",
                 $time, got.row_index, got);
        mismatches++;
        return;
      end
      want = rows_due.pop_front();
      rows_checked++;
      compare("row_index", 32'(want.row_index), 32'(got.row_index));
      compare("pixel_0", want.pixel_0, got.pixel_0);
      compare("pixel_1", want.pixel_1, got.pixel_1);
      compare("pixel_2", want.pixel_2, got.pixel_2);
      compare("pixel_3", want.pixel_3, got.pixel_3);
      compare("last_row", 32'(want.last_row), 32'(got.last_row));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  dxt_row_scoreboard sb;
  int unsigned blocks_sent;
  int unsigned format_writes;
  int unsigned cycle_count;
  int unsigned stall_run;
  int unsigned quiet_cycles;
  bit          progress;

  dxt_block_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_block(input in_word_t blk);
    int unsigned gap;
    int unsigned pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (((blocks_sent / 40) % 4) != 3) begin
      if (pick >= 92) gap = $urandom_range(8, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_block(blk);
    blocks_sent++;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (sb.rows_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Output stalls: mostly short, a few long runs, and calm stretches.
  always @(posedge clk_i) begin
    int unsigned pick;
    cycle_count++;
    pick = $urandom_range(0, 99);
    if (stall_run != 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if (((cycle_count / 300) % 4) == 3 || pick < 70) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_run = (pick >= 97) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        sb.check_row(out_data_o);
        progress = 1'b1;
      end
      if (in_valid_i && !in_stall_o) progress = 1'b1;
      if (cfg_valid_i && cfg_ready_o) progress = 1'b1;
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no word moved for %0d cycles", $time, QuietLimit);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] e0, e1;
    logic [63:0] alpha;
    int unsigned shape;
    in_word_t    blk;
    sb            = new();
    blocks_sent   = 0;
    format_writes = 0;
    cycle_count   = 0;
    stall_run     = 0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= FMT_DXT1;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= PhaseFormat[ph];
      do begin
        @(posedge clk_i);
      end while (!cfg_ready_o);
      sb.format_code = PhaseFormat[ph];
      format_writes++;
      cfg_valid_i <= 1'b0;
      if (ph < 4) begin
        for (int k = 0; k < NumDirected; k++) send_block(DirectedBlocks[k]);
      end
      for (int i = 0; i < RandPerPhase; i++) begin
        e0    = 16'($urandom);
        e1    = 16'($urandom);
        alpha = {$urandom, $urandom};
        shape = $urandom_range(0, 9);
        if (shape == 0) e1 = e0;
        else if (shape == 1) e0 = 16'hFFFF;
        else if (shape == 2) e1 = 16'h0000;
        else if (shape == 3) alpha[15:8] = alpha[7:0];
        blk.color_block = {$urandom, e1, e0};
        blk.alpha_block = alpha;
        send_block(blk);
      end
      in_valid_i <= 1'b0;
    end
    wait_idle();
    $display("Decoded %0d blocks into %0d row words over %0d format settings,",
             blocks_sent, sb.rows_checked, format_writes);
    $display("covering DXT1, DXT3, DXT5 and the unused format code; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.rows_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
